@@ hw/rtl/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

    // field widths of the channels
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned ATTR_W = 8;
    localparam int unsigned CELL_W = CHAR_W + ATTR_W;
    localparam int unsigned ROW_FIELD_W = 5;
    localparam int unsigned COL_FIELD_W = 7;

    // character and attribute codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_COLOR  = 8'h07;

    // operation codes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL
    } state_t;

    typedef struct packed {
        logic                   operation;
        logic [CHAR_W-1:0]      char_code;
        logic [ROW_FIELD_W-1:0] read_row;
        logic [COL_FIELD_W-1:0] read_column;
    } in_item_t;

    typedef struct packed {
        logic [CELL_W-1:0]      cell_value;
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [COL_FIELD_W-1:0] cursor_column;
        logic                   scrolled;
    } out_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/text_console_writer_top.sv @@
// Text console writer: a screen of ROWS x COLUMNS cells (attribute byte over
// character byte) with a cursor.
// Input channel (in_valid / in_stall / in_data) carries one transaction per
// operation: a put of char_code at the cursor, or a read of one cell.
// Output channel (out_valid / out_stall / out_data) returns exactly one
// transaction per operation, held in an output register until taken.
// Configuration: cfg_we / cfg_wdata write the attribute used for puts.
// A put or an out-of-range read shows its result in the cycle after acceptance,
// an in-range read after the registered RAM read and the ST_READ state.
// Throughput: one put or out-of-range read per cycle while the output is not
// stalled; an in-range read blocks input while in ST_READ, and a put that
// scrolls blocks input while the new bottom row is blanked through the single
// RAM port. Scrolling moves a row offset, no data is copied.
// All addresses come from one shared row*COLUMNS+column address unit.
// Reset: cursor goes home, attribute becomes 0x07, and a clearing pass writes
// grey spaces to all ROWS*COLUMNS cells, one per cycle; input is stalled
// until the pass is done.
// A stalled output holds its transaction; input is stalled while the output
// register is full and out_stall is high.
`default_nettype none

module text_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire tcw_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output tcw_pkg::out_item_t     out_data,
    input  wire logic              cfg_we,
    input  wire logic [tcw_pkg::ATTR_W-1:0] cfg_wdata
);

    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
    localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);

    tcw_pkg::state_t    state_reg, state_next;
    logic [RW-1:0]      cur_row_reg, cur_row_next;
    logic [CW-1:0]      cur_col_reg, cur_col_next;
    logic [RW-1:0]      base_reg, base_next;
    logic [RW-1:0]      sweep_row_reg, sweep_row_next;
    logic [CW-1:0]      sweep_col_reg, sweep_col_next;
    logic [tcw_pkg::ATTR_W-1:0] color_reg;
    logic               out_valid_reg, out_valid_next;
    tcw_pkg::out_item_t out_reg, out_next;

    logic [RW-1:0]      log_row;
    logic [RW:0]        row_sum;
    logic [RW-1:0]      phys_row;
    logic [RW-1:0]      addr_row;
    logic [CW-1:0]      addr_col;
    logic [AW-1:0]      ram_addr;
    logic               ram_we;
    logic [tcw_pkg::CELL_W-1:0] ram_wdata;
    logic [tcw_pkg::CELL_W-1:0] ram_rdata;
    logic               read_in_range;
    logic               wrap;
    logic               scroll;

    // logical to physical row through the scroll offset
    always_comb
    begin
        log_row = (in_data.operation == tcw_pkg::OP_READ) ? RW'(in_data.read_row)
                                                          : cur_row_reg;
        row_sum = {1'b0, log_row} + {1'b0, base_reg};
        if (row_sum >= (RW+1)'(ROWS))
        begin
            phys_row = RW'(row_sum - (RW+1)'(ROWS));
        end
        else
        begin
            phys_row = RW'(row_sum);
        end
        read_in_range = (int'(in_data.read_row) < ROWS)
                     && (int'(in_data.read_column) < COLUMNS);
    end

    // shared address unit
    assign ram_addr = AW'(addr_row) * COLS_A + AW'(addr_col);

    tcw_ram #(
        .WIDTH(tcw_pkg::CELL_W),
        .DEPTH(DEPTH)
    ) u_screen (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        base_next      = base_reg;
        sweep_row_next = sweep_row_reg;
        sweep_col_next = sweep_col_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_wdata      = {color_reg, tcw_pkg::BLANK_CODE};
        addr_row       = sweep_row_reg;
        addr_col       = sweep_col_reg;
        in_stall       = 1'b1;
        wrap           = 1'b0;
        scroll         = 1'b0;

        case (state_reg)
            tcw_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::BLANK_CODE};
                if (sweep_col_reg == LAST_COL)
                begin
                    sweep_col_next = '0;
                    if (sweep_row_reg == LAST_ROW)
                    begin
                        sweep_row_next = '0;
                        state_next     = tcw_pkg::ST_IDLE;
                    end
                    else
                    begin
                        sweep_row_next = sweep_row_reg + 1'b1;
                    end
                end
                else
                begin
                    sweep_col_next = sweep_col_reg + 1'b1;
                end
            end

            tcw_pkg::ST_IDLE:
            begin
                in_stall = out_valid_reg && out_stall;
                addr_row = phys_row;
                addr_col = (in_data.operation == tcw_pkg::OP_READ)
                         ? CW'(in_data.read_column) : cur_col_reg;
                if (in_valid && !in_stall)
                begin
                    if (in_data.operation == tcw_pkg::OP_READ)
                    begin
                        if (read_in_range)
                        begin
                            state_next = tcw_pkg::ST_READ;
                        end
                        else
                        begin
                            out_next.cell_value    = '0;
                            out_next.cursor_row    = tcw_pkg::ROW_FIELD_W'(cur_row_reg);
                            out_next.cursor_column = tcw_pkg::COL_FIELD_W'(cur_col_reg);
                            out_next.scrolled      = 1'b0;
                            out_valid_next         = 1'b1;
                        end
                    end
                    else
                    begin
                        if (in_data.char_code == tcw_pkg::NEWLINE_CODE)
                        begin
                            wrap = 1'b1;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {color_reg, in_data.char_code};
                            if (cur_col_reg == LAST_COL)
                            begin
                                wrap = 1'b1;
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + 1'b1;
                            end
                        end
                        // move to next row, scroll past the last one
                        if (wrap)
                        begin
                            cur_col_next = '0;
                            if (cur_row_reg == LAST_ROW)
                            begin
                                scroll         = 1'b1;
                                sweep_row_next = base_reg;
                                sweep_col_next = '0;
                                base_next      = (base_reg == LAST_ROW) ? '0
                                                                        : base_reg + 1'b1;
                                state_next     = tcw_pkg::ST_SCROLL;
                            end
                            else
                            begin
                                cur_row_next = cur_row_reg + 1'b1;
                            end
                        end
                        out_next.cell_value    = '0;
                        out_next.cursor_row    = tcw_pkg::ROW_FIELD_W'(cur_row_next);
                        out_next.cursor_column = tcw_pkg::COL_FIELD_W'(cur_col_next);
                        out_next.scrolled      = scroll;
                        out_valid_next         = 1'b1;
                    end
                end
            end

            tcw_pkg::ST_READ:
            begin
                out_next.cell_value    = ram_rdata;
                out_next.cursor_row    = tcw_pkg::ROW_FIELD_W'(cur_row_reg);
                out_next.cursor_column = tcw_pkg::COL_FIELD_W'(cur_col_reg);
                out_next.scrolled      = 1'b0;
                out_valid_next         = 1'b1;
                state_next             = tcw_pkg::ST_IDLE;
            end

            tcw_pkg::ST_SCROLL:
            begin
                // blank the new bottom row
                ram_we = 1'b1;
                if (sweep_col_reg == LAST_COL)
                begin
                    sweep_col_next = '0;
                    state_next     = tcw_pkg::ST_IDLE;
                end
                else
                begin
                    sweep_col_next = sweep_col_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = tcw_pkg::ST_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::ST_CLEAR;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            base_reg      <= '0;
            sweep_row_reg <= '0;
            sweep_col_reg <= '0;
            color_reg     <= tcw_pkg::RESET_COLOR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            base_reg      <= base_next;
            sweep_row_reg <= sweep_row_next;
            sweep_col_reg <= sweep_col_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                color_reg <= cfg_wdata;
            end
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tcw_ram.sv @@
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

@@ tb/tb_text_console_writer_top.sv @@
`timescale 1ns / 1ps

module tb_text_console_writer_top;

    localparam int TB_COLS = 80;
    localparam int TB_ROWS = 25;
    localparam int PHASE_OPS = 396;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    tcw_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    tcw_pkg::out_item_t out_data;
    logic               cfg_we = 1'b0;
    logic [tcw_pkg::ATTR_W-1:0] cfg_wdata = '0;

    // no random idling on either side while set
    logic calm = 1'b0;

    // pending operations and expected replies
    tcw_pkg::in_item_t  op_queue[$];
    tcw_pkg::out_item_t console_replies[$];

    // console shadow state
    logic [tcw_pkg::CELL_W-1:0] screen_model [0:TB_ROWS*TB_COLS-1];
    int                         cur_row_model;
    int                         cur_col_model;
    logic [tcw_pkg::ATTR_W-1:0] color_model;

    int fail_count = 0;
    int put_count = 0;
    int read_count = 0;
    int scroll_count = 0;
    int color_settings = 1;

    text_console_writer_top #(
        .COLUMNS(TB_COLS),
        .ROWS   (TB_ROWS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // cursor to next line, scroll the shadow screen when it falls off the bottom
    function automatic logic console_next_row();
        int i;
        cur_col_model = 0;
        cur_row_model++;
        if (cur_row_model < TB_ROWS)
            return 1'b0;
        for (i = 0; i < (TB_ROWS - 1) * TB_COLS; i++)
            screen_model[i] = screen_model[i + TB_COLS];
        for (i = 0; i < TB_COLS; i++)
            screen_model[(TB_ROWS - 1) * TB_COLS + i] = {color_model, tcw_pkg::BLANK_CODE};
        cur_row_model = TB_ROWS - 1;
        return 1'b1;
    endfunction

    // apply one operation to the shadow console and queue its reply
    function automatic void apply_console_op(tcw_pkg::in_item_t op);
        tcw_pkg::out_item_t rep;
        rep = '0;
        if (op.operation == tcw_pkg::OP_READ)
        begin
            read_count++;
            if (int'(op.read_row) < TB_ROWS && int'(op.read_column) < TB_COLS)
                rep.cell_value = screen_model[int'(op.read_row) * TB_COLS
                                              + int'(op.read_column)];
        end
        else if (op.char_code == tcw_pkg::NEWLINE_CODE)
        begin
            put_count++;
            rep.scrolled = console_next_row();
        end
        else
        begin
            put_count++;
            screen_model[cur_row_model * TB_COLS + cur_col_model] = {color_model, op.char_code};
            cur_col_model++;
            if (cur_col_model >= TB_COLS)
                rep.scrolled = console_next_row();
        end
        if (rep.scrolled)
            scroll_count++;
        rep.cursor_row = cur_row_model[tcw_pkg::ROW_FIELD_W-1:0];
        rep.cursor_column = cur_col_model[tcw_pkg::COL_FIELD_W-1:0];
        console_replies.push_back(rep);
    endfunction

    function automatic tcw_pkg::in_item_t mk_put(logic [tcw_pkg::CHAR_W-1:0] ch);
        tcw_pkg::in_item_t op;
        op.operation = tcw_pkg::OP_PUT;
        op.char_code = ch;
        op.read_row = tcw_pkg::ROW_FIELD_W'($urandom);
        op.read_column = tcw_pkg::COL_FIELD_W'($urandom);
        return op;
    endfunction

    function automatic tcw_pkg::in_item_t mk_read(int row, int col);
        tcw_pkg::in_item_t op;
        op.operation = tcw_pkg::OP_READ;
        op.char_code = tcw_pkg::CHAR_W'($urandom);
        op.read_row = tcw_pkg::ROW_FIELD_W'(row);
        op.read_column = tcw_pkg::COL_FIELD_W'(col);
        return op;
    endfunction

    // input driver: predicts on acceptance, then offers the next transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                apply_console_op(in_data);
            if (!in_valid || !in_stall)
            begin
                if (op_queue.size() != 0 && (calm || $urandom_range(99) >= 6))
                begin
                    in_valid <= 1'b1;
                    in_data <= op_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor: compare each reply transaction and throttle the receiver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (console_replies.size() == 0)
                begin
                    $error("reply with nothing expected: %h", out_data);
                    fail_count++;
                end
                else
                begin
                    tcw_pkg::out_item_t exp_rep;
                    exp_rep = console_replies.pop_front();
                    if (out_data.cell_value !== exp_rep.cell_value)
                    begin
                        $error("cell_value expected %h actual %h",
                               exp_rep.cell_value, out_data.cell_value);
                        fail_count++;
                    end
                    if (out_data.cursor_row !== exp_rep.cursor_row)
                    begin
                        $error("cursor_row expected %0d actual %0d",
                               exp_rep.cursor_row, out_data.cursor_row);
                        fail_count++;
                    end
                    if (out_data.cursor_column !== exp_rep.cursor_column)
                    begin
                        $error("cursor_column expected %0d actual %0d",
                               exp_rep.cursor_column, out_data.cursor_column);
                        fail_count++;
                    end
                    if (out_data.scrolled !== exp_rep.scrolled)
                    begin
                        $error("scrolled expected %b actual %b",
                               exp_rep.scrolled, out_data.scrolled);
                        fail_count++;
                    end
                end
            end
            out_stall <= !calm && ($urandom_range(99) < 6);
        end
    end

    // wait for every reply, then let any row blanking finish
    task automatic wait_drained();
        while (op_queue.size() != 0 || in_valid || console_replies.size() != 0)
            @(posedge clk);
        repeat (TB_COLS + 20) @(posedge clk);
    endtask

    task automatic write_text_color(logic [tcw_pkg::ATTR_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        color_model = value;
        color_settings++;
        @(negedge clk);
    endtask

    // random traffic built from text lines, newline runs, reads and noise
    task automatic queue_random_ops(int target);
        int count;
        int len;
        int i;
        logic [tcw_pkg::CHAR_W-1:0] ch;
        tcw_pkg::in_item_t op;
        count = 0;
        while (count < target)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    len = ($urandom_range(3) == 0) ? $urandom_range(100) : $urandom_range(20);
                    for (i = 0; i < len; i++)
                    begin
                        if ($urandom_range(1))
                            ch = tcw_pkg::CHAR_W'(8'h21 + $urandom_range(93));
                        else
                            ch = tcw_pkg::CHAR_W'($urandom);
                        op_queue.push_back(mk_put(ch));
                    end
                    count += len;
                    if ($urandom_range(3) != 0)
                    begin
                        op_queue.push_back(mk_put(tcw_pkg::NEWLINE_CODE));
                        count++;
                    end
                end
                4:
                begin
                    len = $urandom_range(1, 30);
                    for (i = 0; i < len; i++)
                        op_queue.push_back(mk_put(tcw_pkg::NEWLINE_CODE));
                    count += len;
                end
                5, 6, 7:
                begin
                    len = $urandom_range(1, 8);
                    for (i = 0; i < len; i++)
                        op_queue.push_back(mk_read($urandom_range(TB_ROWS - 1),
                                                   $urandom_range(TB_COLS - 1)));
                    count += len;
                end
                8:
                begin
                    op.operation = 1'($urandom);
                    op.char_code = tcw_pkg::CHAR_W'($urandom);
                    op.read_row = tcw_pkg::ROW_FIELD_W'($urandom);
                    op.read_column = tcw_pkg::COL_FIELD_W'($urandom);
                    op_queue.push_back(op);
                    count++;
                end
                default:
                begin
                    if ($urandom_range(1))
                        op_queue.push_back(mk_read($urandom_range(TB_ROWS, 31),
                                                   $urandom_range(127)));
                    else
                        op_queue.push_back(mk_read($urandom_range(31),
                                                   $urandom_range(TB_COLS, 127)));
                    count++;
                end
            endcase
        end
    endtask

    // sequence of phases
    initial
    begin
        int i;
        logic [tcw_pkg::ATTR_W-1:0] colors [5];
        colors[0] = 8'hFF;
        colors[1] = 8'h00;
        colors[2] = tcw_pkg::ATTR_W'($urandom);
        colors[3] = tcw_pkg::RESET_COLOR;
        colors[4] = tcw_pkg::ATTR_W'($urandom);

        for (i = 0; i < TB_ROWS * TB_COLS; i++)
            screen_model[i] = {tcw_pkg::RESET_COLOR, tcw_pkg::BLANK_CODE};
        cur_row_model = 0;
        cur_col_model = 0;
        color_model = tcw_pkg::RESET_COLOR;

        // directed: reset contents, range edges, byte extremes, newline
        op_queue.push_back(mk_read(0, 0));
        op_queue.push_back(mk_read(TB_ROWS - 1, TB_COLS - 1));
        op_queue.push_back(mk_read(TB_ROWS, 0));
        op_queue.push_back(mk_read(0, TB_COLS));
        op_queue.push_back(mk_read(31, 127));
        op_queue.push_back(mk_put(8'h00));
        op_queue.push_back(mk_put(8'hFF));
        op_queue.push_back(mk_put(8'h41));
        op_queue.push_back(mk_put(8'h09));
        op_queue.push_back(mk_put(8'h0B));
        op_queue.push_back(mk_put(tcw_pkg::NEWLINE_CODE));
        op_queue.push_back(mk_put(8'h7E));
        op_queue.push_back(mk_put(tcw_pkg::NEWLINE_CODE));
        op_queue.push_back(mk_put(tcw_pkg::NEWLINE_CODE));
        op_queue.push_back(mk_read(0, 0));
        op_queue.push_back(mk_read(0, 1));
        op_queue.push_back(mk_read(0, 2));
        op_queue.push_back(mk_read(0, 5));
        op_queue.push_back(mk_read(1, 0));
        op_queue.push_back(mk_read(1, 1));
        op_queue.push_back(mk_read(2, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < 5; p++)
        begin
            wait_drained();
            write_text_color(colors[p]);
            calm <= (p == 3);
            if (p == 0)
            begin
                // full line to force a wrap, then enough newlines to scroll
                for (i = 0; i < TB_COLS; i++)
                    op_queue.push_back(mk_put(tcw_pkg::CHAR_W'(8'h30 + (i % 40))));
                for (i = 0; i < TB_ROWS + 1; i++)
                    op_queue.push_back(mk_put(tcw_pkg::NEWLINE_CODE));
                op_queue.push_back(mk_read(TB_ROWS - 1, 0));
                op_queue.push_back(mk_read(TB_ROWS - 2, TB_COLS - 1));
            end
            queue_random_ops(PHASE_OPS);
        end

        wait_drained();
        repeat (2 * TB_COLS) @(posedge clk);

        $display("covered %0d puts and %0d reads with %0d scrolls",
                 put_count, read_count, scroll_count);
        $display("under %0d attribute settings, %0d mismatches", color_settings, fail_count);
        if (fail_count == 0 && console_replies.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("timeout with %0d replies outstanding", console_replies.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ text_console_writer_top.f @@
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/text_console_writer_top.sv
tb/tb_text_console_writer_top.sv
